// ===== sv/yuyv_pair_to_bgr_macros.svh =====
// ----------------------------------------------------------------------------
// YUYV pair to BGR assertion macros
// Shared concurrent assertion shorthands, clocked on clk and disabled
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef YUYV_PAIR_TO_BGR_MACROS_SVH
`define YUYV_PAIR_TO_BGR_MACROS_SVH

// Plain property that must hold at every clock edge outside reset.
`define YB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: when the antecedent sequence matches, the consequent holds.
`define YB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/yuyv2bgr_pkg.sv =====
// ----------------------------------------------------------------------------
// YUYV pair to BGR package
// Payload types, register indexes, reset values, the sample difference and the coefficient multiply.
// ----------------------------------------------------------------------------
package yuyv2bgr_pkg;

	localparam int PIX_W     = 8;
	localparam int COEF_W    = 11;
	localparam int DIFF_W    = PIX_W + 1;
	// An 11-bit unsigned coefficient times a 9-bit signed difference stays
	// within 20 signed bits; three such terms stay within 22.
	localparam int PROD_W    = 20;
	localparam int SUM_W     = 22;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = COEF_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LUMA_GAIN     = 3'd0,
		REG_CR_TO_RED     = 3'd1,
		REG_CB_TO_GREEN   = 3'd2,
		REG_CR_TO_GREEN   = 3'd3,
		REG_CB_TO_BLUE    = 3'd4,
		REG_LUMA_OFFSET   = 3'd5,
		REG_CHROMA_OFFSET = 3'd6
	} reg_idx_t;

	localparam logic [COEF_W-1:0] RST_LUMA_GAIN     = 11'd298;
	localparam logic [COEF_W-1:0] RST_CR_TO_RED     = 11'd409;
	localparam logic [COEF_W-1:0] RST_CB_TO_GREEN   = 11'd100;
	localparam logic [COEF_W-1:0] RST_CR_TO_GREEN   = 11'd208;
	localparam logic [COEF_W-1:0] RST_CB_TO_BLUE    = 11'd516;
	localparam logic [PIX_W-1:0]  RST_LUMA_OFFSET   = 8'd16;
	localparam logic [PIX_W-1:0]  RST_CHROMA_OFFSET = 8'd128;

	typedef struct packed {
		logic [PIX_W-1:0] luma_first;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] luma_second;
		logic [PIX_W-1:0] chroma_red;
		logic             frame_last_in;
	} pair_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue_first;
		logic [PIX_W-1:0] green_first;
		logic [PIX_W-1:0] red_first;
		logic [PIX_W-1:0] blue_second;
		logic [PIX_W-1:0] green_second;
		logic [PIX_W-1:0] red_second;
		logic             frame_last_out;
	} pair_out_t;

	// Signed difference of two unsigned samples.
	function automatic logic signed [DIFF_W-1:0] sample_diff(
		input logic [PIX_W-1:0] sample,
		input logic [PIX_W-1:0] offset
	);
		sample_diff = signed'({1'b0, sample}) - signed'({1'b0, offset});
	endfunction

	// Unsigned coefficient times signed difference.
	function automatic logic signed [PROD_W-1:0] coef_mul(
		input logic [COEF_W-1:0]        coef,
		input logic signed [DIFF_W-1:0] diff
	);
		logic signed [PROD_W-1:0] coef_ext;
		logic signed [PROD_W-1:0] diff_ext;
		coef_ext = PROD_W'(signed'({1'b0, coef}));
		diff_ext = PROD_W'(diff);
		coef_mul = coef_ext * diff_ext;
	endfunction

endpackage

// ===== sv/yuyv_pair_to_bgr.sv =====
// ----------------------------------------------------------------------------
// YUYV pair to BGR converter
// Converts one YUYV 4:2:2 macropixel into two BGR pixels per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while out_stall does not hold it
// back, and returns one transaction per accepted one, in order. Each
// transaction carries two luma samples that share one Cb and
// one Cr sample; the result carries two clamped BGR pixels and a copy of the
// last-pair flag. The four register stages are: offset removal, the six
// coefficient multiplies, the channel sums, and the shift, clamp and output
// register. Each stage advances when the stage after it is empty or advancing,
// so bubbles collapse and a stalled output only holds back what is behind it.
// The configuration registers (gain, chroma weights and offsets, with
// COEF_FRAC_BITS fraction bits in the coefficients) reset to BT.601 studio
// range values and should be written only while no transaction is in flight.
// Writes to an index beyond the register list are ignored.
module yuyv_pair_to_bgr #(
	parameter int COEF_FRAC_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  yuyv2bgr_pkg::pair_in_t               in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output yuyv2bgr_pkg::pair_out_t              out_data,
	input  logic                                 cfg_wr_en,
	input  logic [yuyv2bgr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [yuyv2bgr_pkg::CFG_DAT_W-1:0]   cfg_data
);

	localparam int PIX_W  = yuyv2bgr_pkg::PIX_W;
	localparam int COEF_W = yuyv2bgr_pkg::COEF_W;
	localparam int DIFF_W = yuyv2bgr_pkg::DIFF_W;
	localparam int PROD_W = yuyv2bgr_pkg::PROD_W;
	localparam int SUM_W  = yuyv2bgr_pkg::SUM_W;
	// Bits of the sum at and above this position mean the channel exceeds 255.
	localparam int OVF_LSB = COEF_FRAC_BITS + PIX_W;

	// Configuration registers.
	logic [COEF_W-1:0] luma_gain_q;
	logic [COEF_W-1:0] cr_to_red_q;
	logic [COEF_W-1:0] cb_to_green_q;
	logic [COEF_W-1:0] cr_to_green_q;
	logic [COEF_W-1:0] cb_to_blue_q;
	logic [PIX_W-1:0]  luma_offset_q;
	logic [PIX_W-1:0]  chroma_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_gain_q     <= yuyv2bgr_pkg::RST_LUMA_GAIN;
			cr_to_red_q     <= yuyv2bgr_pkg::RST_CR_TO_RED;
			cb_to_green_q   <= yuyv2bgr_pkg::RST_CB_TO_GREEN;
			cr_to_green_q   <= yuyv2bgr_pkg::RST_CR_TO_GREEN;
			cb_to_blue_q    <= yuyv2bgr_pkg::RST_CB_TO_BLUE;
			luma_offset_q   <= yuyv2bgr_pkg::RST_LUMA_OFFSET;
			chroma_offset_q <= yuyv2bgr_pkg::RST_CHROMA_OFFSET;
		end else if (cfg_wr_en) begin
			unique case (yuyv2bgr_pkg::reg_idx_t'(cfg_index))
				yuyv2bgr_pkg::REG_LUMA_GAIN:     luma_gain_q     <= cfg_data;
				yuyv2bgr_pkg::REG_CR_TO_RED:     cr_to_red_q     <= cfg_data;
				yuyv2bgr_pkg::REG_CB_TO_GREEN:   cb_to_green_q   <= cfg_data;
				yuyv2bgr_pkg::REG_CR_TO_GREEN:   cr_to_green_q   <= cfg_data;
				yuyv2bgr_pkg::REG_CB_TO_BLUE:    cb_to_blue_q    <= cfg_data;
				yuyv2bgr_pkg::REG_LUMA_OFFSET:   luma_offset_q   <= cfg_data[PIX_W-1:0];
				yuyv2bgr_pkg::REG_CHROMA_OFFSET: chroma_offset_q <= cfg_data[PIX_W-1:0];
				default: begin
					// Index past the register list: the write is dropped.
				end
			endcase
		end
	end

	// Stage valids and the per-stage advance enables. A stage loads when it
	// is empty or its contents move on in the same clock.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !valid_s4 || !out_stall;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: remove the luma footroom and the chroma center.
	logic signed [DIFF_W-1:0] dy1_s1, dy2_s1, db_s1, dr_s1;
	logic                     last_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dy1_s1  <= yuyv2bgr_pkg::sample_diff(in_data.luma_first, luma_offset_q);
			dy2_s1  <= yuyv2bgr_pkg::sample_diff(in_data.luma_second, luma_offset_q);
			db_s1   <= yuyv2bgr_pkg::sample_diff(in_data.chroma_blue, chroma_offset_q);
			dr_s1   <= yuyv2bgr_pkg::sample_diff(in_data.chroma_red, chroma_offset_q);
			last_s1 <= in_data.frame_last_in;
		end
	end

	// Stage 2: the six coefficient products. The chroma terms are shared by
	// both pixels of the pair.
	logic signed [PROD_W-1:0] yt1_s2, yt2_s2, rcr_s2, gcb_s2, gcr_s2, bcb_s2;
	logic                     last_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			yt1_s2  <= yuyv2bgr_pkg::coef_mul(luma_gain_q, dy1_s1);
			yt2_s2  <= yuyv2bgr_pkg::coef_mul(luma_gain_q, dy2_s1);
			rcr_s2  <= yuyv2bgr_pkg::coef_mul(cr_to_red_q, dr_s1);
			gcb_s2  <= yuyv2bgr_pkg::coef_mul(cb_to_green_q, db_s1);
			gcr_s2  <= yuyv2bgr_pkg::coef_mul(cr_to_green_q, dr_s1);
			bcb_s2  <= yuyv2bgr_pkg::coef_mul(cb_to_blue_q, db_s1);
			last_s2 <= last_s1;
		end
	end

	// Stage 3: channel sums at full precision.
	logic signed [SUM_W-1:0] red1_s3, green1_s3, blue1_s3;
	logic signed [SUM_W-1:0] red2_s3, green2_s3, blue2_s3;
	logic                    last_s3;
	logic signed [SUM_W-1:0] green_chroma;

	assign green_chroma = SUM_W'(gcb_s2) + SUM_W'(gcr_s2);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			red1_s3   <= SUM_W'(yt1_s2) + SUM_W'(rcr_s2);
			green1_s3 <= SUM_W'(yt1_s2) - green_chroma;
			blue1_s3  <= SUM_W'(yt1_s2) + SUM_W'(bcb_s2);
			red2_s3   <= SUM_W'(yt2_s2) + SUM_W'(rcr_s2);
			green2_s3 <= SUM_W'(yt2_s2) - green_chroma;
			blue2_s3  <= SUM_W'(yt2_s2) + SUM_W'(bcb_s2);
			last_s3   <= last_s2;
		end
	end

	// Floor shift by the fraction bits, then clamp to 0..255. A negative sum
	// stays negative after the shift and clamps to zero; any set bit above
	// the eight integer bits means the value is past 255.
	function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
		if (sum[SUM_W-1]) begin
			clamp_channel = '0;
		end else if (|sum[SUM_W-2:OVF_LSB]) begin
			clamp_channel = '1;
		end else begin
			clamp_channel = sum[OVF_LSB-1:COEF_FRAC_BITS];
		end
	endfunction

	// Stage 4: clamp into the output register.
	yuyv2bgr_pkg::pair_out_t out_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			out_s4.blue_first     <= clamp_channel(blue1_s3);
			out_s4.green_first    <= clamp_channel(green1_s3);
			out_s4.red_first      <= clamp_channel(red1_s3);
			out_s4.blue_second    <= clamp_channel(blue2_s3);
			out_s4.green_second   <= clamp_channel(green2_s3);
			out_s4.red_second     <= clamp_channel(red2_s3);
			out_s4.frame_last_out <= last_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = out_s4;

endmodule

// ===== sv/yuyv2bgr_checker.sv =====
// ----------------------------------------------------------------------------
// YUYV pair to BGR port checker
// Watches the converter's ports for handshake and pipeline flow slips.
// ----------------------------------------------------------------------------
`include "yuyv_pair_to_bgr_macros.svh"

module yuyv2bgr_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input yuyv2bgr_pkg::pair_out_t out_data
);

	// A stalled result stays and does not change.
	`YB_ASSERT_IMPL(a_out_hold, out_valid && out_stall, ##1 (out_valid && $stable(out_data)), "stalled output transaction changed or vanished")

	// With an empty output register the whole pipeline can advance.
	`YB_ASSERT(a_no_false_stall, out_valid || !in_stall, "input stalled while the output register is empty")

	// An accepted transaction reaches the output while out_stall stays low.
	`YB_ASSERT_IMPL(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall, ##1 out_valid, "accepted transaction did not reach the output in time")

endmodule

bind yuyv_pair_to_bgr yuyv2bgr_checker u_yuyv2bgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
